@@ hdl/cvp_pkg.sv @@
// ----------------------------------------------------------------------------
// Camera vertex projection package
// Shared constants, register codes, side-band types and helper functions.
// ----------------------------------------------------------------------------
package cvp_pkg;

  // Screen size in pixels
  localparam int unsigned SCREEN_WIDTH  = 400;
  localparam int unsigned SCREEN_HEIGHT = 400;

  // Screen centre and right/bottom limits in Q16.16
  localparam logic [33:0] CENTER_X = 34'((SCREEN_WIDTH / 2) * 65536);
  localparam logic [33:0] CENTER_Y = 34'((SCREEN_HEIGHT / 2) * 65536);
  localparam logic [31:0] LIMIT_X  = 32'(SCREEN_WIDTH * 65536);
  localparam logic [31:0] LIMIT_Y  = 32'(SCREEN_HEIGHT * 65536);

  localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] INT32_MIN = 32'h8000_0000;

  // Pipeline layout: six front stages, one divider set-up stage,
  // one stage per quotient bit, then the output register
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_BASE  = 6;
  localparam int unsigned NSTG      = DIV_BASE + DIV_STEPS + 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X  = 4'd0,
    CFG_OFFSET_Y  = 4'd1,
    CFG_OFFSET_Z  = 4'd2,
    CFG_YAW_COS   = 4'd3,
    CFG_YAW_SIN   = 4'd4,
    CFG_PITCH_COS = 4'd5,
    CFG_PITCH_SIN = 4'd6,
    CFG_FOCAL     = 4'd7
  } cfg_reg_e;

  localparam logic [31:0] RST_OFFSET_Z = 32'hFFFB_0000;   // -5.0
  localparam logic [15:0] TRIG_ONE     = 16'sd16384;
  localparam logic [11:0] RST_FOCAL    = 12'd200;

  // Flags that travel with an item through the divider
  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic        pos_x;
    logic        pos_y;
    logic        nz_x;
    logic        nz_y;
    logic        ov_x;
    logic        ov_y;
    logic        dzero;
    logic        front;
    logic [31:0] depth;
  } side_t;

  // Saturate a Q2.14 sine or cosine to [-1.0, +1.0]
  function automatic logic signed [15:0] clamp_trig(input logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (v > $signed(TRIG_ONE)) r = $signed(TRIG_ONE);
    if (v < -$signed(TRIG_ONE)) r = -$signed(TRIG_ONE);
    return r;
  endfunction

endpackage

@@ hdl/cvp_intf.sv @@
// ----------------------------------------------------------------------------
// Camera vertex projection channels
// Valid/ready channels for vertices, results and configuration writes.
// ----------------------------------------------------------------------------

// Vertex channel
interface cvp_vertex_if;
  logic        valid;
  logic        ready;
  logic [31:0] vertex_x;
  logic [31:0] vertex_y;
  logic [31:0] vertex_z;
  modport source (output valid, vertex_x, vertex_y, vertex_z, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, output ready);
endinterface

// Result channel
interface cvp_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] screen_x;
  logic [31:0] screen_y;
  logic [31:0] view_depth;
  logic        in_front;
  logic        on_screen;
  modport source (output valid, screen_x, screen_y, view_depth, in_front, on_screen,
                  input ready);
  modport sink   (input valid, screen_x, screen_y, view_depth, in_front, on_screen,
                  output ready);
endinterface

// Configuration write channel
interface cvp_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/camera_vertex_projection_unit.sv @@
// ----------------------------------------------------------------------------
// Camera vertex projection unit
// Camera offset, yaw and pitch rotation, perspective divide, screen flags.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                         | transfer
//  vtx_i    | in  | vertex_x, vertex_y, vertex_z                    | valid & ready
//  res_o    | out | screen_x, screen_y, view_depth, in_front, on_scr| valid & ready
//  cfg_i    | in  | index, data                                     | valid & ready
//
//  One vertex per cycle sustained while the result channel is not
//  stalled; the 32-stage restoring divider gives one quotient bit per stage.
//  Reset clears all valid bits and loads the register defaults.
//  Each stage holds while its successor is full and stalled; bubbles
//  collapse, so input is taken whenever any stage is empty or res_o is ready.
//  Configuration writes are always taken (ready tied high).
// ----------------------------------------------------------------------------
module camera_vertex_projection_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  cvp_vertex_if.sink          vtx_i,
  cvp_result_if.source        res_o,
  cvp_cfg_if.sink             cfg_i
);

  localparam int unsigned NS = cvp_pkg::NSTG;
  localparam int unsigned DS = cvp_pkg::DIV_STEPS;
  localparam int unsigned DB = cvp_pkg::DIV_BASE;

  // Configuration registers (trig values stored clamped)
  logic signed [31:0] off_x_q, off_y_q, off_z_q;
  logic signed [15:0] yc_q, ys_q, pc_q, ps_q;
  logic        [11:0] focal_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
      off_z_q <= cvp_pkg::RST_OFFSET_Z;
      yc_q    <= cvp_pkg::TRIG_ONE;
      ys_q    <= '0;
      pc_q    <= cvp_pkg::TRIG_ONE;
      ps_q    <= '0;
      focal_q <= cvp_pkg::RST_FOCAL;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        cvp_pkg::CFG_OFFSET_X:  off_x_q <= cfg_i.data;
        cvp_pkg::CFG_OFFSET_Y:  off_y_q <= cfg_i.data;
        cvp_pkg::CFG_OFFSET_Z:  off_z_q <= cfg_i.data;
        cvp_pkg::CFG_YAW_COS:   yc_q    <= cvp_pkg::clamp_trig(cfg_i.data[15:0]);
        cvp_pkg::CFG_YAW_SIN:   ys_q    <= cvp_pkg::clamp_trig(cfg_i.data[15:0]);
        cvp_pkg::CFG_PITCH_COS: pc_q    <= cvp_pkg::clamp_trig(cfg_i.data[15:0]);
        cvp_pkg::CFG_PITCH_SIN: ps_q    <= cvp_pkg::clamp_trig(cfg_i.data[15:0]);
        cvp_pkg::CFG_FOCAL:     focal_q <= cfg_i.data[11:0];
        default: ;
      endcase
    end
  end

  // Valid bits and per-stage enables
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || res_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign vtx_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= vtx_i.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 0: camera offset
  logic signed [32:0] x0_q, y0_q, z0_q;
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x0_q <= $signed({vtx_i.vertex_x[31], vtx_i.vertex_x}) + $signed({off_x_q[31], off_x_q});
      y0_q <= $signed({vtx_i.vertex_y[31], vtx_i.vertex_y}) + $signed({off_y_q[31], off_y_q});
      z0_q <= $signed({vtx_i.vertex_z[31], vtx_i.vertex_z}) + $signed({off_z_q[31], off_z_q});
    end
  end

  // Stage 1: yaw products
  logic signed [48:0] pxc_q, pzs_q, pxs_q, pzc_q;
  logic signed [32:0] y1_q;
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pxc_q <= x0_q * yc_q;
      pzs_q <= z0_q * ys_q;
      pxs_q <= x0_q * ys_q;
      pzc_q <= z0_q * yc_q;
      y1_q  <= y0_q;
    end
  end

  // Stage 2: yaw sums, round to nearest (ties up)
  logic signed [49:0] sum_x1, sum_z1;
  logic signed [35:0] x2_q, z2_q;
  logic signed [32:0] y2_q;
  always_comb begin
    sum_x1 = 50'(pxc_q) - 50'(pzs_q) + 50'sd8192;
    sum_z1 = 50'(pxs_q) + 50'(pzc_q) + 50'sd8192;
  end
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      x2_q <= sum_x1[49:14];
      z2_q <= sum_z1[49:14];
      y2_q <= y1_q;
    end
  end

  // Stage 3: pitch products
  logic signed [51:0] pyc_q, pzs2_q, pys_q, pzc2_q;
  logic signed [35:0] x3_q;
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      pyc_q  <= y2_q * pc_q;
      pzs2_q <= z2_q * ps_q;
      pys_q  <= y2_q * ps_q;
      pzc2_q <= z2_q * pc_q;
      x3_q   <= x2_q;
    end
  end

  // Stage 4: pitch sums, rounded
  logic signed [52:0] sum_y2, sum_z2;
  logic signed [38:0] y4_q, z4_q;
  logic signed [35:0] x4_q;
  always_comb begin
    sum_y2 = 53'(pyc_q) - 53'(pzs2_q) + 53'sd8192;
    sum_z2 = 53'(pys_q) + 53'(pzc2_q) + 53'sd8192;
  end
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      y4_q <= sum_y2[52:14];
      z4_q <= sum_z2[52:14];
      x4_q <= x3_q;
    end
  end

  // Stage 5: magnitudes times focal scale, depth and sign flags
  logic [35:0] abs_x;
  logic [38:0] abs_y, abs_z;
  logic [31:0] depth_d;
  logic [47:0] mnx_q;
  logic [50:0] mny_q;
  logic [38:0] md5_q;
  logic        negx5_q, negy5_q, posx5_q, posy5_q, dz5_q, front5_q;
  logic [31:0] depth5_q;
  always_comb begin
    abs_x = x4_q[35] ? 36'(-x4_q) : 36'(x4_q);
    abs_y = y4_q[38] ? 39'(-y4_q) : 39'(y4_q);
    abs_z = z4_q[38] ? 39'(-z4_q) : 39'(z4_q);
    if (!z4_q[38] && (|z4_q[37:31])) depth_d = cvp_pkg::INT32_MAX;
    else if (z4_q[38] && !(&z4_q[37:31])) depth_d = cvp_pkg::INT32_MIN;
    else depth_d = z4_q[31:0];
  end
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      mnx_q    <= abs_x * focal_q;
      mny_q    <= abs_y * focal_q;
      md5_q    <= abs_z;
      negx5_q  <= x4_q[35] ^ z4_q[38];
      negy5_q  <= y4_q[38] ^ z4_q[38];
      posx5_q  <= !x4_q[35] && (x4_q != '0);
      posy5_q  <= !y4_q[38] && (y4_q != '0);
      dz5_q    <= (z4_q == '0);
      front5_q <= z4_q[38];
      depth5_q <= depth_d;
    end
  end

  // Divider pipeline: set-up stage then one quotient bit per stage
  logic [38:0]       rx_q [DS+1];
  logic [38:0]       ry_q [DS+1];
  logic [31:0]       qx_q [DS+1];
  logic [31:0]       qy_q [DS+1];
  logic [38:0]       md_q [DS+1];
  cvp_pkg::side_t    sd_q [DS+1];
  cvp_pkg::side_t    side_d;

  always_comb begin
    side_d.neg_x = negx5_q;
    side_d.neg_y = negy5_q;
    side_d.pos_x = posx5_q;
    side_d.pos_y = posy5_q;
    side_d.nz_x  = (mnx_q != '0);
    side_d.nz_y  = (mny_q != '0);
    // quotient would not fit 32 bits
    side_d.ov_x  = {7'd0, mnx_q} >= {md5_q, 16'd0};
    side_d.ov_y  = {4'd0, mny_q} >= {md5_q, 16'd0};
    side_d.dzero = dz5_q;
    side_d.front = front5_q;
    side_d.depth = depth5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[DB]) begin
      rx_q[0] <= {7'd0, mnx_q[47:16]};
      ry_q[0] <= {4'd0, mny_q[50:16]};
      qx_q[0] <= {mnx_q[15:0], 16'd0};
      qy_q[0] <= {mny_q[15:0], 16'd0};
      md_q[0] <= md5_q;
      sd_q[0] <= side_d;
    end
  end

  for (genvar k = 1; k <= DS; k++) begin : g_div
    logic [39:0] tx, ty;
    logic        bx, by;
    always_comb begin
      tx = {rx_q[k-1], qx_q[k-1][31]};
      ty = {ry_q[k-1], qy_q[k-1][31]};
      bx = tx >= {1'b0, md_q[k-1]};
      by = ty >= {1'b0, md_q[k-1]};
    end
    always_ff @(posedge clk_i) begin
      if (en[DB+k]) begin
        rx_q[k] <= bx ? 39'(tx - {1'b0, md_q[k-1]}) : tx[38:0];
        ry_q[k] <= by ? 39'(ty - {1'b0, md_q[k-1]}) : ty[38:0];
        qx_q[k] <= {qx_q[k-1][30:0], bx};
        qy_q[k] <= {qy_q[k-1][30:0], by};
        md_q[k] <= md_q[k-1];
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // Output stage: sign, centre, saturation, special cases, bounds test
  cvp_pkg::side_t     so;
  logic signed [33:0] sgn_x, sgn_y, cen_x, cen_y;
  logic        [31:0] sx_d, sy_d;
  logic               onscr_d;
  logic        [31:0] sx_q, sy_q, dep_q;
  logic               front_q, onscr_q;

  always_comb begin
    so    = sd_q[DS];
    sgn_x = so.neg_x ? -$signed({2'b00, qx_q[DS]}) : $signed({2'b00, qx_q[DS]});
    sgn_y = so.neg_y ? -$signed({2'b00, qy_q[DS]}) : $signed({2'b00, qy_q[DS]});
    cen_x = sgn_x + $signed(cvp_pkg::CENTER_X);
    cen_y = sgn_y + $signed(cvp_pkg::CENTER_Y);

    if (so.dzero) begin
      if (!so.nz_x)     sx_d = cvp_pkg::CENTER_X[31:0];
      else if (so.pos_x) sx_d = cvp_pkg::INT32_MAX;
      else              sx_d = cvp_pkg::INT32_MIN;
    end else if (so.ov_x) begin
      sx_d = so.neg_x ? cvp_pkg::INT32_MIN : cvp_pkg::INT32_MAX;
    end else if (cen_x[33:31] != {3{cen_x[33]}}) begin
      sx_d = cen_x[33] ? cvp_pkg::INT32_MIN : cvp_pkg::INT32_MAX;
    end else begin
      sx_d = cen_x[31:0];
    end

    if (so.dzero) begin
      if (!so.nz_y)     sy_d = cvp_pkg::CENTER_Y[31:0];
      else if (so.pos_y) sy_d = cvp_pkg::INT32_MAX;
      else              sy_d = cvp_pkg::INT32_MIN;
    end else if (so.ov_y) begin
      sy_d = so.neg_y ? cvp_pkg::INT32_MIN : cvp_pkg::INT32_MAX;
    end else if (cen_y[33:31] != {3{cen_y[33]}}) begin
      sy_d = cen_y[33] ? cvp_pkg::INT32_MIN : cvp_pkg::INT32_MAX;
    end else begin
      sy_d = cen_y[31:0];
    end

    onscr_d = so.front && !sx_d[31] && (sx_d <= cvp_pkg::LIMIT_X)
                       && !sy_d[31] && (sy_d <= cvp_pkg::LIMIT_Y);
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      dep_q   <= so.depth;
      front_q <= so.front;
      onscr_q <= onscr_d;
    end
  end

  assign res_o.valid      = v_q[NS-1];
  assign res_o.screen_x   = sx_q;
  assign res_o.screen_y   = sy_q;
  assign res_o.view_depth = dep_q;
  assign res_o.in_front   = front_q;
  assign res_o.on_screen  = onscr_q;

endmodule

@@ hdl/cvp_checker.sv @@
// ----------------------------------------------------------------------------
// Camera vertex projection checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cvp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [31:0] screen_x_i,
  input logic [31:0] view_depth_i,
  input logic        in_front_i,
  input logic        on_screen_i
);

  // A stalled result stays valid and keeps its screen x
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(screen_x_i))
    else $error("stalled result changed");

  // In-front flag follows the sign of the saturated depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (in_front_i == view_depth_i[31]))
    else $error("in_front disagrees with depth sign");

  // On screen only for points in front
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && on_screen_i |-> in_front_i)
    else $error("on_screen without in_front");

  // On screen means a non-negative screen x
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && on_screen_i |-> !screen_x_i[31])
    else $error("on_screen with negative screen x");

endmodule

bind camera_vertex_projection_unit cvp_checker u_cvp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .screen_x_i   (res_o.screen_x),
  .view_depth_i (res_o.view_depth),
  .in_front_i   (res_o.in_front),
  .on_screen_i  (res_o.on_screen)
);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Camera vertex projection unit testbench
// Drives vertices through the projection unit under a series of camera
// settings, predicts each projected point in the testbench and compares the
// results in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 60;

  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
  } vertex_t;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] depth;
    logic        front;
    logic        onscr;
  } point_t;

  logic clk_i;
  logic rst_ni;

  cvp_vertex_if vtx ();
  cvp_result_if res ();
  cvp_cfg_if    cfg ();

  camera_vertex_projection_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  // Camera register copy used by the predictor
  logic [31:0] cam_reg [8];

  vertex_t pending_vertices [$];
  point_t  expected_points  [$];
  int      mismatches;
  bit      no_idle;

  // Append one vertex to the pending queue
  function automatic void add_vertex(vertex_t v);
    pending_vertices = {pending_vertices, v};
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint trig_of(logic [31:0] raw);
    longint t;
    t = longint'($signed(raw[15:0]));
    if (t > 16384) t = 16384;
    if (t < -16384) t = -16384;
    return t;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Perspective divide of one coordinate, truncated toward zero
  function automatic longint perspective(longint n, longint f, longint d, longint centre);
    logic [63:0] mn;
    logic [63:0] md;
    logic [63:0] q;
    mn = 64'(n < 0 ? -n : n) * 64'(f);
    md = 64'(d < 0 ? -d : d);
    if (d == 0) begin
      if (mn == 0) return centre;
      return (n > 0) ? 64'sd2147483647 : -64'sd2147483648;
    end
    q = (mn << 16) / md;
    return sat32((((n < 0) != (d < 0)) ? -longint'(q) : longint'(q)) + centre);
  endfunction

  function automatic point_t project_vertex(vertex_t v);
    longint x, y, z, yc, ys, pc, ps, f, x1, z1, y2, z2, sx, sy;
    point_t p;
    x  = longint'($signed(v.vx)) + longint'($signed(cam_reg[cvp_pkg::CFG_OFFSET_X]));
    y  = longint'($signed(v.vy)) + longint'($signed(cam_reg[cvp_pkg::CFG_OFFSET_Y]));
    z  = longint'($signed(v.vz)) + longint'($signed(cam_reg[cvp_pkg::CFG_OFFSET_Z]));
    yc = trig_of(cam_reg[cvp_pkg::CFG_YAW_COS]);
    ys = trig_of(cam_reg[cvp_pkg::CFG_YAW_SIN]);
    pc = trig_of(cam_reg[cvp_pkg::CFG_PITCH_COS]);
    ps = trig_of(cam_reg[cvp_pkg::CFG_PITCH_SIN]);
    f  = longint'(cam_reg[cvp_pkg::CFG_FOCAL][11:0]);
    // rounding to nearest, ties up: add half then floor
    x1 = (x * yc - z * ys + 8192) >>> 14;
    z1 = (x * ys + z * yc + 8192) >>> 14;
    y2 = (y * pc - z1 * ps + 8192) >>> 14;
    z2 = (y * ps + z1 * pc + 8192) >>> 14;
    sx = perspective(x1, f, z2, longint'(cvp_pkg::SCREEN_WIDTH / 2) * 65536);
    sy = perspective(y2, f, z2, longint'(cvp_pkg::SCREEN_HEIGHT / 2) * 65536);
    p.sx    = sx[31:0];
    p.sy    = sy[31:0];
    p.depth = 32'(sat32(z2));
    p.front = (z2 < 0);
    p.onscr = p.front && sx >= 0 && sx <= longint'(cvp_pkg::SCREEN_WIDTH) * 65536 &&
              sy >= 0 && sy <= longint'(cvp_pkg::SCREEN_HEIGHT) * 65536;
    return p;
  endfunction

  // Vertex driver
  int vtx_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx.valid    <= 1'b0;
      vtx.vertex_x <= '0;
      vtx.vertex_y <= '0;
      vtx.vertex_z <= '0;
      vtx_gap      <= 0;
    end else if (!vtx.valid || vtx.ready) begin
      if (vtx_gap > 0) begin
        vtx_gap   <= vtx_gap - 1;
        vtx.valid <= 1'b0;
      end else if (pending_vertices.size() > 0) begin
        vertex_t v;
        v = pending_vertices.pop_front();
        vtx.valid    <= 1'b1;
        vtx.vertex_x <= v.vx;
        vtx.vertex_y <= v.vy;
        vtx.vertex_z <= v.vz;
        vtx_gap      <= gap_len();
      end else begin
        vtx.valid <= 1'b0;
      end
    end
  end

  // Result stall generator
  int res_stall;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
      res_stall <= 0;
    end else if (res_stall > 0) begin
      res_stall <= res_stall - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
      if (res.valid && res.ready) res_stall <= gap_len();
    end
  end

  // Prediction on each vertex transfer, checking on each result transfer
  int idle_cycles;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (vtx.valid && vtx.ready)
        expected_points = {expected_points,
                           project_vertex({vtx.vertex_x, vtx.vertex_y, vtx.vertex_z})};
      if (res.valid && res.ready) begin
        point_t got, want;
        got = {res.screen_x, res.screen_y, res.view_depth, res.in_front, res.on_screen};
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_points.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: sx %h/%h sy %h/%h depth %h/%h front %b/%b onscr %b/%b",
                       want.sx, got.sx, want.sy, got.sy, want.depth, got.depth,
                       want.front, got.front, want.onscr, got.onscr);
          end
        end
      end
      // watchdog on cycles with no transfer at all
      if ((vtx.valid && vtx.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [3:0] idx, logic [31:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid <= 1'b0;
    case (idx)
      cvp_pkg::CFG_OFFSET_X, cvp_pkg::CFG_OFFSET_Y, cvp_pkg::CFG_OFFSET_Z:
        cam_reg[idx] = data;
      cvp_pkg::CFG_YAW_COS, cvp_pkg::CFG_YAW_SIN, cvp_pkg::CFG_PITCH_COS,
      cvp_pkg::CFG_PITCH_SIN:
        cam_reg[idx] = {16'h0, data[15:0]};
      cvp_pkg::CFG_FOCAL: cam_reg[idx] = {20'h0, data[11:0]};
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_vertices.size() > 0 || expected_points.size() > 0 || vtx.valid)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] coord_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 524288)) - 262144);
      2: return 32'($signed($urandom_range(0, 65536 * 16)) - 65536 * 8);
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  task automatic add_random(int count);
    vertex_t v;
    repeat (count) begin
      v.vx = coord_value();
      v.vy = coord_value();
      v.vz = coord_value();
      // some vertices land on the camera plane
      if ($urandom_range(0, 9) == 0) v.vz = -cam_reg[cvp_pkg::CFG_OFFSET_Z];
      add_vertex(v);
    end
  endtask

  task automatic set_camera(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [15:0] yc, logic [15:0] ys, logic [15:0] pc,
                            logic [15:0] ps, logic [11:0] f);
    write_reg(cvp_pkg::CFG_OFFSET_X, ox);
    write_reg(cvp_pkg::CFG_OFFSET_Y, oy);
    write_reg(cvp_pkg::CFG_OFFSET_Z, oz);
    write_reg(cvp_pkg::CFG_YAW_COS, {16'($urandom_range(0, 65535)), yc});
    write_reg(cvp_pkg::CFG_YAW_SIN, {16'h0, ys});
    write_reg(cvp_pkg::CFG_PITCH_COS, {16'h0, pc});
    write_reg(cvp_pkg::CFG_PITCH_SIN, {16'h0, ps});
    write_reg(cvp_pkg::CFG_FOCAL, {20'($urandom_range(0, 1048575)), f});
  endtask

  // Stimulus and end of run
  initial begin
    int phase;
    logic [15:0] c, s;
    rst_ni    = 1'b0;
    no_idle   = 1'b0;
    mismatches = 0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    cam_reg[cvp_pkg::CFG_OFFSET_X]  = 32'h0;
    cam_reg[cvp_pkg::CFG_OFFSET_Y]  = 32'h0;
    cam_reg[cvp_pkg::CFG_OFFSET_Z]  = cvp_pkg::RST_OFFSET_Z;
    cam_reg[cvp_pkg::CFG_YAW_COS]   = 32'(cvp_pkg::TRIG_ONE);
    cam_reg[cvp_pkg::CFG_YAW_SIN]   = 32'h0;
    cam_reg[cvp_pkg::CFG_PITCH_COS] = 32'(cvp_pkg::TRIG_ONE);
    cam_reg[cvp_pkg::CFG_PITCH_SIN] = 32'h0;
    cam_reg[cvp_pkg::CFG_FOCAL]     = 32'(cvp_pkg::RST_FOCAL);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset camera, centre, extremes, camera plane, behind camera
    add_vertex({32'h0, 32'h0, 32'h0});
    add_vertex({32'h0001_0000, 32'hFFFF_0000, 32'h0});
    add_vertex({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    add_vertex({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    add_vertex({32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000});
    add_vertex({32'h0, 32'h0, 32'h0005_0000});
    add_vertex({32'h0001_0000, 32'hFFFF_0000, 32'h0005_0000});
    add_vertex({32'hFFFF_0000, 32'h0001_0000, 32'h0005_0000});
    add_vertex({32'h0, 32'h0, 32'h000A_0000});
    add_vertex({32'h0000_8000, 32'h0000_8000, 32'h0004_0000});
    add_vertex({32'h0, 32'h0, 32'h0004_FFFF});
    add_vertex({32'h0, 32'h0, 32'h0005_0001});
    add_vertex({32'h0050_0000, 32'h0, 32'h0});
    add_vertex({32'h0, 32'hFFB0_0000, 32'h0});
    wait_drained();

    // Extreme camera: offsets at the limits, trig out of range, focal max
    set_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
               16'h7FFF, 16'h8000, 16'hC000, 16'h4000, 12'hFFF);
    add_vertex({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    add_vertex({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    add_vertex({32'h0, 32'h0, 32'h0});
    add_random(20);
    wait_drained();
    // focal zero and the ignored register indexes
    set_camera(32'h0, 32'h0, 32'hFFFB_0000, 16'hC000, 16'h0, 16'h4000, 16'h0, 12'h0);
    write_reg(4'd8, $urandom());
    write_reg(4'd15, $urandom());
    add_random(20);
    wait_drained();

    // Random cameras, one phase each
    for (phase = 0; phase < 8; phase++) begin
      no_idle = (phase % 3 == 1);
      c = 16'($urandom_range(0, 32768) - 16384);
      s = 16'($urandom_range(0, 32768) - 16384);
      if (phase == 0) begin
        c = 16'h4000;
        s = 16'h0;
      end
      set_camera(32'($signed($urandom_range(0, 262144)) - 131072),
                 32'($signed($urandom_range(0, 262144)) - 131072),
                 (phase == 7) ? $urandom() :
                   32'(-$signed($urandom_range(65536, 65536 * 10))),
                 c, s,
                 (phase % 2) ? 16'h4000 : 16'($urandom_range(0, 32768) - 16384),
                 (phase % 2) ? 16'h0 : 16'($urandom_range(0, 32768) - 16384),
                 (phase == 5) ? 12'hFFF : 12'($urandom_range(1, 4095)));
      add_random(60);
      wait_drained();
    end

    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
